### hdl/vdcd_pkg.sv
package vdcd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ENDED   = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // A header may take at most this many bytes.
    localparam logic [3:0] MAX_HEADER_BYTES = 4'd10;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

endpackage

### hdl/varint_delta_chunk_deframer_top.sv
// Chunk deframer for a byte stream.
// The slave channel takes one stream byte per item in s_tdata[7:0]. Each chunk
// opens with a little-endian base-128 varint header; the first header and any
// header after a zero-size chunk is an absolute size, the others are a
// zigzag-coded delta (plus one) against the previous size. A zero header ends
// the stream.
// The master channel gives one item per payload byte (m_tuser is the kind,
// m_tlast marks the final byte of a chunk), one item for the end of stream
// and one for a framing error. Header bytes produce no item. After the end or
// an error every further byte is taken and dropped until reset.
// An accepted byte's item is registered at the output. Throughput is one byte
// per cycle while s_tready is high: the parser registers are updated by one
// shift-and-merge of the header byte and one add or subtract of SIZE_BITS bits.
// A result register and a one-entry skid register sit at the output, so while
// the receiver stalls, bytes are still taken until one more item is waiting;
// s_tready falls only while the skid register is full, straight from a register.
// Reset clears the parser and the valid flags of both output registers; the
// block is ready from the moment reset is released.
module varint_delta_chunk_deframer_top #(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [1:0] out_kind
    output logic       m_tlast     // chunk_end
);
    import vdcd_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [63:0]            varint_acc_reg, varint_acc_next;
    logic [3:0]             varint_count_reg, varint_count_next;
    logic [SIZE_BITS-1:0]   previous_size_reg, previous_size_next;
    logic [SIZE_BITS-1:0]   bytes_left_reg, bytes_left_next;

    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;
    logic                   skid_valid_reg, skid_valid_next;
    result_t                skid_reg, skid_next;

    logic                   accept;
    logic                   take;
    logic [5:0]             shift;
    logic [63:0]            acc_merged;
    logic [3:0]             count_inc;
    logic [62:0]            half;
    logic [SIZE_BITS-1:0]   half_lo;
    logic                   abs_over;
    logic                   half_over;
    logic [SIZE_BITS:0]     size_sum;
    logic [SIZE_BITS:0]     size_diff;
    logic                   size_err;
    logic [SIZE_BITS-1:0]   size_new;
    logic                   last_byte;
    logic                   res_valid;
    result_t                res;

    assign accept = s_tvalid && s_tready;
    assign take   = out_valid_reg && m_tready;

    // Header datapath: merge the new seven value bits into the accumulator.
    assign shift      = 6'(7 * varint_count_reg);
    assign acc_merged = varint_acc_reg | (64'(s_tdata[6:0]) << shift);
    assign count_inc  = varint_count_reg + 4'd1;

    // For a delta header the zigzag magnitude is the header halved, and the
    // sign is negative when the header is even.
    assign half      = acc_merged[63:1];
    assign half_lo   = half[SIZE_BITS-1:0];
    assign abs_over  = (acc_merged >> SIZE_BITS) != 64'd0;
    assign half_over = (half >> SIZE_BITS) != 63'd0;
    assign size_sum  = {1'b0, previous_size_reg} + {1'b0, half_lo};
    assign size_diff = {1'b0, previous_size_reg} - {1'b0, half_lo};

    always_comb
    begin
        if (previous_size_reg == '0)
        begin
            size_err = abs_over;
            size_new = acc_merged[SIZE_BITS-1:0];
        end
        else if (acc_merged[0])
        begin
            size_err = half_over || size_sum[SIZE_BITS];
            size_new = size_sum[SIZE_BITS-1:0];
        end
        else
        begin
            size_err = half_over || size_diff[SIZE_BITS];
            size_new = size_diff[SIZE_BITS-1:0];
        end
    end

    assign last_byte = bytes_left_reg <= SIZE_BITS'(1);

    // Next state of the parser.
    always_comb
    begin
        phase_next         = phase_reg;
        varint_acc_next    = varint_acc_reg;
        varint_count_next  = varint_count_reg;
        previous_size_next = previous_size_reg;
        bytes_left_next    = bytes_left_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    if (bytes_left_reg != '0)
                    begin
                        bytes_left_next = bytes_left_reg - SIZE_BITS'(1);
                    end
                    if (last_byte)
                    begin
                        phase_next        = PH_HEADER;
                        varint_acc_next   = '0;
                        varint_count_next = '0;
                    end
                end
                PH_HEADER:
                begin
                    varint_acc_next   = acc_merged;
                    varint_count_next = count_inc;
                    if (s_tdata[7])
                    begin
                        if (count_inc >= MAX_HEADER_BYTES)
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    else
                    begin
                        varint_acc_next   = '0;
                        varint_count_next = '0;
                        if (acc_merged == 64'd0)
                        begin
                            phase_next = PH_ENDED;
                        end
                        else if (size_err)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else
                        begin
                            previous_size_next = size_new;
                            bytes_left_next    = size_new;
                            phase_next = (size_new == '0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Result caused by the accepted byte.
    always_comb
    begin
        res_valid = 1'b0;
        res       = '{kind: KIND_PAYLOAD, data: 8'd0, last: 1'b0};
        if (accept)
        begin
            case (phase_reg)
                PH_PAYLOAD:
                begin
                    res_valid = 1'b1;
                    res       = '{kind: KIND_PAYLOAD, data: s_tdata, last: last_byte};
                end
                PH_HEADER:
                begin
                    if (s_tdata[7])
                    begin
                        if (count_inc >= MAX_HEADER_BYTES)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_ERROR;
                        end
                    end
                    else if (acc_merged == 64'd0)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_END;
                    end
                    else if (size_err)
                    begin
                        res_valid = 1'b1;
                        res.kind  = KIND_ERROR;
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    // Output register with a one-item skid register behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !take)
        begin
            if (res_valid)
            begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
        else
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            varint_acc_reg    <= '0;
            varint_count_reg  <= '0;
            previous_size_reg <= '0;
            bytes_left_reg    <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            varint_acc_reg    <= varint_acc_next;
            varint_count_reg  <= varint_count_next;
            previous_size_reg <= previous_size_next;
            bytes_left_reg    <= bytes_left_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.data;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

### hdl/vdcd_checker.sv
module vdcd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);
    import vdcd_pkg::*;

    logic in_seen;

    assign in_seen = s_tvalid && (s_tdata == s_tdata);

    // Nothing follows an end-of-stream or error item once it has been taken.
    a_final_item: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser != KIND_PAYLOAD) |=> !m_tvalid)
        else $error("item after end of stream or error");

    // End and error items carry no byte and no chunk end.
    a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata == 8'd0 && !m_tlast))
        else $error("status item with payload bits");

    // The input side is held off only after the receiver stalled a valid item.
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready || (in_seen && !s_tready)) |->
            (m_tvalid && $past(m_tvalid && !m_tready)))
        else $error("input stalled without a stalled output");

    // A stalled item holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output item changed");

endmodule

bind varint_delta_chunk_deframer_top vdcd_checker u_vdcd_checker (.*);

### test/varint_delta_chunk_deframer_top_test.sv
module varint_delta_chunk_deframer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vdcd_pkg::*;

    localparam int SIZE_W       = 32;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 1400;

    // Tracks the deframer state for every accepted stream byte and keeps the
    // items that the block owes on its master side, oldest first.
    class deframe_scoreboard;
        phase_t      phase;
        logic [63:0] hdr_acc;
        logic [3:0]  hdr_count;
        logic [63:0] last_size;
        logic [63:0] left_in_chunk;
        logic [63:0] size_max;
        result_t     owed_items[$];
        int          mismatches;
        int          payload_seen;
        int          ignored_bytes;

        function new(int size_bits);
            phase         = PH_HEADER;
            hdr_acc       = '0;
            hdr_count     = '0;
            last_size     = '0;
            left_in_chunk = '0;
            size_max      = (64'd1 << size_bits) - 64'd1;
            mismatches    = 0;
            payload_seen  = 0;
            ignored_bytes = 0;
        endfunction

        function void owe(kind_t k, logic [7:0] d, logic l);
            result_t r;
            r.kind = k;
            r.data = d;
            r.last = l;
            owed_items.push_back(r);
        endfunction

        function void framing_error();
            phase = PH_ERROR;
            owe(KIND_ERROR, 8'h00, 1'b0);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [63:0] hdr;
            logic [63:0] zz;
            logic [63:0] mag;
            logic [63:0] chunk_size;
            if (phase == PH_PAYLOAD) begin
                owe(KIND_PAYLOAD, b, left_in_chunk <= 64'd1);
                if (left_in_chunk > 0)
                    left_in_chunk--;
                if (left_in_chunk == 0) begin
                    phase     = PH_HEADER;
                    hdr_acc   = '0;
                    hdr_count = '0;
                end
                return;
            end
            if (phase != PH_HEADER) begin
                ignored_bytes++;
                return;
            end
            // Value bits that land above bit 63 simply fall off the shift.
            hdr_acc   = hdr_acc | ({57'd0, b[6:0]} << ((7 * hdr_count) & 63));
            hdr_count = hdr_count + 4'd1;
            if (b[7]) begin
                if (hdr_count >= MAX_HEADER_BYTES)
                    framing_error();
                return;
            end
            hdr       = hdr_acc;
            hdr_acc   = '0;
            hdr_count = '0;
            if (hdr == 0) begin
                phase = PH_ENDED;
                owe(KIND_END, 8'h00, 1'b0);
                return;
            end
            if (last_size == 0) begin
                if (hdr > size_max) begin
                    framing_error();
                    return;
                end
                chunk_size = hdr;
            end
            else begin
                zz = hdr - 64'd1;
                if (zz[0]) begin
                    mag = (zz >> 1) + 64'd1;
                    if (mag > last_size) begin
                        framing_error();
                        return;
                    end
                    chunk_size = last_size - mag;
                end
                else begin
                    mag = zz >> 1;
                    if (last_size > size_max || mag > size_max - last_size) begin
                        framing_error();
                        return;
                    end
                    chunk_size = last_size + mag;
                end
            end
            last_size     = chunk_size;
            left_in_chunk = chunk_size;
            phase         = (chunk_size == 0) ? PH_HEADER : PH_PAYLOAD;
        endfunction

        function void check_item(logic [1:0] k, logic [7:0] d, logic l);
            result_t want;
            if (owed_items.size() == 0) begin
                $display("%0t: unexpected item kind %0d byte %02h last %0b", $time, k, d, l);
                mismatches++;
                return;
            end
            want = owed_items.pop_front();
            if (want.kind == KIND_PAYLOAD)
                payload_seen++;
            if (k != want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, k);
                mismatches++;
            end
            if (d != want.data) begin
                $display("%0t: byte expected %02h actual %02h", $time, want.data, d);
                mismatches++;
            end
            if (l != want.last) begin
                $display("%0t: chunk end expected %0b actual %0b", $time, want.last, l);
                mismatches++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    deframe_scoreboard sb = new(SIZE_W);

    logic [63:0] tx_size;       // chunk size as the sender sees it
    bit          tx_calm;
    bit          rx_calm;
    int          idle_cycles;
    int          chunks_sent;
    int          empty_chunks;
    string       stream_close;

    varint_delta_chunk_deframer_top #(
        .SIZE_BITS(SIZE_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 99) < 30)
            gap = idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
    endtask

    // Little-endian base-128 with pad extra groups of zero value bits, ten bytes at most.
    task automatic send_varint(input logic [63:0] v, input int pad);
        int n;
        int total;
        logic [63:0] grp;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0)
            n++;
        total = n + pad;
        if (total > 10)
            total = 10;
        for (int i = 0; i < total; i++)
        begin
            grp = v >> (7 * i);
            send_byte({i < total - 1, grp[6:0]});
        end
    endtask

    // Header for the next chunk: absolute after a zero size, else the
    // zigzag-coded difference plus one.
    function automatic logic [63:0] header_for(logic [63:0] next_size);
        if (tx_size == 0)
            return next_size;
        if (next_size >= tx_size)
            return 64'd2 * (next_size - tx_size) + 64'd1;
        return 64'd2 * (tx_size - next_size);
    endfunction

    task automatic send_chunk(input logic [63:0] next_size, input int pad);
        send_varint(header_for(next_size), pad);
        tx_size = next_size;
        chunks_sent++;
        if (next_size == 0)
            empty_chunks++;
        for (int i = 0; i < next_size; i++)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_chunk_bytes(input logic [63:0] next_size, input logic [7:0] b0,
                                    input logic [7:0] b1);
        send_varint(header_for(next_size), 0);
        tx_size = next_size;
        chunks_sent++;
        send_byte(b0);
        if (next_size > 1)
            send_byte(b1);
    endtask

    task automatic close_stream();
        logic [63:0] mag;
        int unsigned pick;
        pick = $urandom_range(0, 5);
        case (pick)
            0:
            begin
                stream_close = "end of stream";
                send_varint(64'd0, $urandom_range(0, 3));
            end
            1:
            begin
                // Ten header bytes whose set value bits all fall off the top, so the header reads zero.
                stream_close = "end of stream through an overlong header";
                repeat (9) send_byte(8'h80);
                send_byte({1'b0, 6'($urandom_range(0, 63)), 1'b0});
            end
            2:
            begin
                stream_close = "header running past ten bytes";
                repeat (10) send_byte({1'b1, 7'($urandom_range(0, 127))});
            end
            3:
            begin
                stream_close = "absolute size above the limit";
                if (tx_size != 0)
                    send_chunk(64'd0, 0);
                if ($urandom_range(0, 3) == 0)
                    send_varint(64'hFFFF_FFFF_FFFF_FFFF, 0);
                else
                    send_varint(sb.size_max + $urandom_range(1, 3), 0);
            end
            4:
            begin
                stream_close = "delta below zero";
                if (tx_size == 0)
                    send_chunk(64'($urandom_range(1, 5)), 0);
                mag = tx_size + $urandom_range(1, 3);
                send_varint(64'd2 * mag, 0);
            end
            default:
            begin
                stream_close = "delta above the limit";
                if (tx_size == 0)
                    send_chunk(64'($urandom_range(1, 5)), 0);
                mag = sb.size_max - tx_size + $urandom_range(1, 3);
                send_varint(64'd2 * mag + 64'd1, 0);
            end
        endcase
    endtask

    initial
    begin : rx_side
        int stall;
        stall = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 299) == 0)
                rx_calm = !rx_calm;
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 25)
                    stall = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_item(m_tuser, m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: nothing moved for %0d cycles", $time, IDLE_LIMIT);
                $display("varint_delta_chunk_deframer_top test failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int sent_before;
        logic [63:0] next_size;
        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= 8'h00;
        tx_size      = 64'd0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        idle_cycles  = 0;
        chunks_sent  = 0;
        empty_chunks = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: one-byte chunk, byte extremes, growing and equal
        // deltas, an overlong header, an empty chunk and an absolute restart.
        send_chunk_bytes(64'd1, 8'h00, 8'h00);
        send_chunk_bytes(64'd2, 8'hFF, 8'h80);
        send_chunk_bytes(64'd2, 8'h7F, 8'h01);
        send_varint(header_for(64'd2), 2);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_chunk(64'd0, 0);
        send_varint(64'd3, 1);
        tx_size = 64'd3;
        for (int i = 0; i < 3; i++)
            send_byte(8'($urandom_range(0, 255)));
        send_chunk(64'd1, 0);

        sent_before = 0;
        while (sent_before < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                tx_calm = !tx_calm;
            case ($urandom_range(0, 19))
                0, 1:    next_size = (tx_size == 0) ? 64'd1 : 64'd0;
                2:       next_size = 64'($urandom_range(13, 64));
                3:       next_size = (tx_size == 0) ? 64'($urandom_range(100, 250)) : tx_size;
                default: next_size = 64'($urandom_range(1, 12));
            endcase
            if ($urandom_range(0, 99) < 15)
                send_chunk(next_size, $urandom_range(1, 8));
            else
                send_chunk(next_size, 0);
            sent_before += int'(next_size) + 1;
        end

        close_stream();
        repeat ($urandom_range(10, 30))
            send_byte(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;

        while (sb.owed_items.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.owed_items.size() != 0)
        begin
            $display("%0t: %0d items never arrived", $time, sb.owed_items.size());
            sb.mismatches++;
        end
        $display("Sent %0d chunks (%0d empty), %0d payload items checked.",
                 chunks_sent, empty_chunks, sb.payload_seen);
        $display("Stream closed by %s; %0d trailing bytes dropped.",
                 stream_close, sb.ignored_bytes);
        if (sb.mismatches == 0)
            $display("varint_delta_chunk_deframer_top test passed");
        else
            $display("varint_delta_chunk_deframer_top test failed");
        $finish;
    end

endmodule

### files.f
hdl/vdcd_pkg.sv
hdl/varint_delta_chunk_deframer_top.sv
hdl/vdcd_checker.sv
test/varint_delta_chunk_deframer_top_test.sv
